FILE: hdl/cae_pkg.sv
// shared types, constants and decode tables for the alu and rmw execute core
package cae_pkg;

  // opcode group field
  localparam logic [1:0] GRP_ALU = 2'b01;
  localparam logic [1:0] GRP_RMW = 2'b10;

  // alu group rows
  localparam logic [2:0] ROW_ORA = 3'd0;
  localparam logic [2:0] ROW_AND = 3'd1;
  localparam logic [2:0] ROW_EOR = 3'd2;
  localparam logic [2:0] ROW_ADC = 3'd3;
  localparam logic [2:0] ROW_STA = 3'd4;
  localparam logic [2:0] ROW_LDA = 3'd5;
  localparam logic [2:0] ROW_CMP = 3'd6;
  localparam logic [2:0] ROW_SBC = 3'd7;

  // rmw group rows
  localparam logic [2:0] ROW_ASL = 3'd0;
  localparam logic [2:0] ROW_ROL = 3'd1;
  localparam logic [2:0] ROW_LSR = 3'd2;
  localparam logic [2:0] ROW_ROR = 3'd3;
  localparam logic [2:0] ROW_STX = 3'd4;
  localparam logic [2:0] ROW_LDX = 3'd5;
  localparam logic [2:0] ROW_DEC = 3'd6;
  localparam logic [2:0] ROW_INC = 3'd7;

  // alu group columns of interest
  localparam logic [2:0] COL_ALU_IMM = 3'b010;
  localparam logic [2:0] COL_ALU_IZY = 3'b100;
  localparam logic [2:0] COL_ALU_ABY = 3'b110;
  localparam logic [2:0] COL_ALU_ABX = 3'b111;

  // rmw group columns of interest
  localparam logic [2:0] COL_RMW_IMM = 3'b000;
  localparam logic [2:0] COL_RMW_ACC = 3'b010;
  localparam logic [2:0] COL_RMW_STP = 3'b100;
  localparam logic [2:0] COL_RMW_IMP = 3'b110;

  // status flag bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  // reset values of the architectural registers
  localparam logic [7:0] ACC_RST = 8'h00;
  localparam logic [7:0] X_RST   = 8'h00;
  localparam logic [7:0] SP_RST  = 8'hFD;
  localparam logic [7:0] P_RST   = 8'h04;

  // decoupling queue
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // operation classes produced by the front end
  typedef enum logic [4:0] {
    KIND_NOP,
    KIND_ORA,
    KIND_AND,
    KIND_EOR,
    KIND_ADC,
    KIND_STA,
    KIND_LDA,
    KIND_CMP,
    KIND_SBC,
    KIND_ASL,
    KIND_ROL,
    KIND_LSR,
    KIND_ROR,
    KIND_DEX,
    KIND_DEC,
    KIND_INC,
    KIND_TXS,
    KIND_TSX,
    KIND_UNSUP
  } cae_kind_t;

  // classified request handed from front to back
  typedef struct packed {
    cae_kind_t  kind;
    logic       use_acc;
    logic [7:0] operand;
    logic [1:0] len;
    logic [2:0] cyc;
  } cae_op_t;

  // alu group length by column
  function automatic logic [1:0] alu_len(input logic [2:0] col);
    logic [1:0] l;
    case (col)
      3'd3, 3'd6, 3'd7: l = 2'd3;
      default:          l = 2'd2;
    endcase
    return l;
  endfunction

  // alu group base cycles by column
  function automatic logic [2:0] alu_cyc(input logic [2:0] col);
    logic [2:0] c;
    case (col)
      3'd0:    c = 3'd6;
      3'd1:    c = 3'd3;
      3'd2:    c = 3'd2;
      3'd4:    c = 3'd5;
      default: c = 3'd4;
    endcase
    return c;
  endfunction

  // rmw group length by column
  function automatic logic [1:0] rmw_len(input logic [2:0] col);
    logic [1:0] l;
    case (col)
      3'd2, 3'd4, 3'd6: l = 2'd1;
      3'd3, 3'd7:       l = 2'd3;
      default:          l = 2'd2;
    endcase
    return l;
  endfunction

  // rmw group base cycles by column
  function automatic logic [2:0] rmw_cyc(input logic [2:0] col);
    logic [2:0] c;
    case (col)
      3'd1:    c = 3'd5;
      3'd3:    c = 3'd6;
      3'd5:    c = 3'd6;
      3'd7:    c = 3'd7;
      default: c = 3'd2;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/cae_front.sv
// front end: opcode field decode, length and cycle count, operation class
module cae_front (
  input  logic            [7:0] in_func,
  input  logic            [7:0] in_operand,
  input  logic                  in_page_crossed,
  output cae_pkg::cae_op_t      op
);
  import cae_pkg::*;

  logic [2:0] aaa;
  logic [2:0] bbb;
  logic [1:0] grp;
  logic       indexed;

  assign aaa     = in_func[7:5];
  assign bbb     = in_func[4:2];
  assign grp     = in_func[1:0];
  assign indexed = (bbb == COL_ALU_IZY) || (bbb == COL_ALU_ABY) || (bbb == COL_ALU_ABX);

  // classify the request
  always_comb begin
    op         = '0;
    op.kind    = KIND_UNSUP;
    op.operand = in_operand;
    op.len     = 2'd1;
    op.cyc     = 3'd0;
    case (grp)
      GRP_ALU: begin
        op.len = alu_len(bbb);
        op.cyc = alu_cyc(bbb) + {2'b00, indexed && in_page_crossed};
        case (aaa)
          ROW_ORA: op.kind = KIND_ORA;
          ROW_AND: op.kind = KIND_AND;
          ROW_EOR: op.kind = KIND_EOR;
          ROW_ADC: op.kind = KIND_ADC;
          ROW_STA: begin
            // store always pays the indexed penalty; immediate store does nothing
            op.kind = (bbb == COL_ALU_IMM) ? KIND_NOP : KIND_STA;
            op.cyc  = alu_cyc(bbb) + {2'b00, indexed};
          end
          ROW_LDA: op.kind = KIND_LDA;
          ROW_CMP: op.kind = KIND_CMP;
          default: op.kind = KIND_SBC;
        endcase
      end
      GRP_RMW: begin
        op.len  = rmw_len(bbb);
        op.cyc  = rmw_cyc(bbb);
        op.kind = KIND_NOP;
        op.use_acc = (bbb == COL_RMW_ACC);
        if (bbb == COL_RMW_STP) begin
          op.kind = KIND_NOP;
        end else if (bbb == COL_RMW_IMP) begin
          if (aaa == ROW_STX) begin
            op.kind = KIND_TXS;
          end else if (aaa == ROW_LDX) begin
            op.kind = KIND_TSX;
          end
        end else if (bbb != COL_RMW_IMM) begin
          case (aaa)
            ROW_ASL: op.kind = KIND_ASL;
            ROW_ROL: op.kind = KIND_ROL;
            ROW_LSR: op.kind = KIND_LSR;
            ROW_ROR: op.kind = KIND_ROR;
            ROW_DEC: op.kind = (bbb == COL_RMW_ACC) ? KIND_DEX : KIND_DEC;
            ROW_INC: op.kind = (bbb == COL_RMW_ACC) ? KIND_NOP : KIND_INC;
            default: op.kind = KIND_NOP;
          endcase
        end
      end
      default: begin
        op.kind = KIND_UNSUP;
      end
    endcase
  end

endmodule

FILE: hdl/cae_queue.sv
// short request queue between front end and execute back end
module cae_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  cae_pkg::cae_op_t      push_op,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output cae_pkg::cae_op_t      pop_op
);
  import cae_pkg::*;

  cae_op_t        mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW-1:0] rd_ptr_nxt;
  logic [QCW-1:0] count_r;
  logic [QCW-1:0] count_nxt;
  logic           push;
  logic           pop;

  assign push_ready = (count_r != QCW'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

FILE: hdl/cae_back.sv
// back end: architectural registers, alu and shifter, result register
module cae_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  op_valid,
  output logic                  op_ready,
  input  cae_pkg::cae_op_t      op,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic            [7:0] out_acc_value,
  output logic            [7:0] out_index_value,
  output logic            [7:0] out_stack_value,
  output logic            [7:0] out_status_byte,
  output logic                  out_mem_write,
  output logic            [7:0] out_mem_data,
  output logic            [1:0] out_instr_length,
  output logic            [2:0] out_cycle_count,
  output logic                  out_unsupported
);
  import cae_pkg::*;

  logic [7:0] acc_r, acc_nxt;
  logic [7:0] x_r, x_nxt;
  logic [7:0] sp_r, sp_nxt;
  logic [7:0] p_r, p_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       wr_nxt;
  logic [7:0] data_nxt;
  logic       unsup_nxt;
  logic [7:0] out_acc_r, out_x_r, out_sp_r, out_p_r, out_data_r;
  logic       out_wr_r, out_unsup_r;
  logic [1:0] out_len_r;
  logic [2:0] out_cyc_r;
  logic       fire;

  logic [7:0] addend;
  logic [8:0] sum;
  logic [7:0] diff;
  logic [7:0] sh_in;
  logic       cin;

  assign op_ready = !out_valid_r || out_ready;
  assign fire     = op_valid && op_ready;

  // shared adder and shifter operands
  assign addend = (op.kind == KIND_SBC) ? ~op.operand : op.operand;
  assign sum    = {1'b0, acc_r} + {1'b0, addend} + {8'b0, p_r[FLAG_C]};
  assign diff   = acc_r - op.operand;
  assign sh_in  = op.use_acc ? acc_r : op.operand;
  assign cin    = p_r[FLAG_C];

  // execute one request
  always_comb begin
    logic [7:0] res;
    logic       upd_zn;
    res       = 8'h00;
    upd_zn    = 1'b0;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    sp_nxt    = sp_r;
    p_nxt     = p_r;
    wr_nxt    = 1'b0;
    data_nxt  = 8'h00;
    unsup_nxt = 1'b0;
    case (op.kind)
      KIND_ORA: begin
        res = acc_r | op.operand; acc_nxt = res; upd_zn = 1'b1;
      end
      KIND_AND: begin
        res = acc_r & op.operand; acc_nxt = res; upd_zn = 1'b1;
      end
      KIND_EOR: begin
        res = acc_r ^ op.operand; acc_nxt = res; upd_zn = 1'b1;
      end
      KIND_ADC, KIND_SBC: begin
        res           = sum[7:0];
        acc_nxt       = res;
        upd_zn        = 1'b1;
        p_nxt[FLAG_C] = sum[8];
        p_nxt[FLAG_V] = (addend[7] ^ res[7]) & (res[7] ^ acc_r[7]);
      end
      KIND_STA: begin
        wr_nxt = 1'b1; data_nxt = acc_r;
      end
      KIND_LDA: begin
        res = op.operand; acc_nxt = res; upd_zn = 1'b1;
      end
      KIND_CMP: begin
        res = diff; upd_zn = 1'b1; p_nxt[FLAG_C] = (op.operand <= acc_r);
      end
      KIND_ASL, KIND_ROL, KIND_LSR, KIND_ROR: begin
        case (op.kind)
          KIND_ASL: begin res = {sh_in[6:0], 1'b0}; p_nxt[FLAG_C] = sh_in[7]; end
          KIND_ROL: begin res = {sh_in[6:0], cin};  p_nxt[FLAG_C] = sh_in[7]; end
          KIND_LSR: begin res = {1'b0, sh_in[7:1]}; p_nxt[FLAG_C] = sh_in[0]; end
          default:  begin res = {cin, sh_in[7:1]};  p_nxt[FLAG_C] = sh_in[0]; end
        endcase
        upd_zn = 1'b1;
        if (op.use_acc) begin
          acc_nxt = res;
        end else begin
          wr_nxt = 1'b1; data_nxt = res;
        end
      end
      KIND_DEX: begin
        res = x_r - 8'd1; x_nxt = res; upd_zn = 1'b1;
      end
      KIND_DEC: begin
        res = op.operand - 8'd1; wr_nxt = 1'b1; data_nxt = res; upd_zn = 1'b1;
      end
      KIND_INC: begin
        res = op.operand + 8'd1; wr_nxt = 1'b1; data_nxt = res; upd_zn = 1'b1;
      end
      KIND_TXS: begin
        sp_nxt = x_r;
      end
      KIND_TSX: begin
        res = sp_r; x_nxt = res; upd_zn = 1'b1;
      end
      KIND_UNSUP: begin
        unsup_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    if (upd_zn) begin
      p_nxt[FLAG_Z] = (res == 8'h00);
      p_nxt[FLAG_N] = res[7];
    end
  end

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // architectural registers and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= ACC_RST;
      x_r         <= X_RST;
      sp_r        <= SP_RST;
      p_r         <= P_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        acc_r <= acc_nxt;
        x_r   <= x_nxt;
        sp_r  <= sp_nxt;
        p_r   <= p_nxt;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_acc_r   <= acc_nxt;
      out_x_r     <= x_nxt;
      out_sp_r    <= sp_nxt;
      out_p_r     <= p_nxt;
      out_wr_r    <= wr_nxt;
      out_data_r  <= data_nxt;
      out_len_r   <= op.len;
      out_cyc_r   <= op.cyc;
      out_unsup_r <= unsup_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_acc_value    = out_acc_r;
  assign out_index_value  = out_x_r;
  assign out_stack_value  = out_sp_r;
  assign out_status_byte  = out_p_r;
  assign out_mem_write    = out_wr_r;
  assign out_mem_data     = out_data_r;
  assign out_instr_length = out_len_r;
  assign out_cycle_count  = out_cyc_r;
  assign out_unsupported  = out_unsup_r;

  // a held result freezes the architectural state
  a_hold_freezes_state: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && out_valid_r && !out_ready) |=>
      (out_valid_r && $stable(acc_r) && $stable(x_r) && $stable(sp_r) && $stable(p_r)))
    else $error("state changed while result stalled");

  // the shown result always matches the registers it reports
  a_result_mirrors_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_acc_r == acc_r && out_x_r == x_r && out_sp_r == sp_r && out_p_r == p_r))
    else $error("result out of step with architectural state");

  // unsupported opcodes report zero in out_cycle_count and length one, and write nothing
  a_unsup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_unsup_r) |-> (out_cyc_r == 3'd0 && !out_wr_r && out_len_r == 2'd1))
    else $error("unsupported result carries activity");

  // no write means zero write data
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wr_r) |-> (out_data_r == 8'h00))
    else $error("write data set without a write");

endmodule

FILE: hdl/cpu_alu_and_rmw_execute_core.sv
// top level of the alu and read-modify-write execute core
//
// Input channel (in_valid / in_ready): one opcode byte, its operand byte and
// the page-crossed flag from the address unit make one request.
// Output channel (out_valid / out_ready): A, X, SP and status after the
// instruction, the memory write request and data, the instruction length,
// the cycle count and the unsupported flag.
// Path: an accepted request is first written into the queue, then taken by
// the back end, whose result register shows it on the output channel.
// Throughput: one instruction per cycle while out_ready stays high, with
// combinational alu and flag logic in the back end; the two-entry queue
// between decode and execute keeps the input open while a result waits.
// Reset (rst_n low, synchronous): queue emptied, no result pending, A and X
// cleared, SP set to 0xFD, status set to 0x04.
// When the receiver stalls the result is held, the back end stops, and the
// queue takes up to two more requests before in_ready drops.
module cpu_alu_and_rmw_execute_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_func,
  input  logic [7:0] in_operand,
  input  logic       in_page_crossed,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_acc_value,
  output logic [7:0] out_index_value,
  output logic [7:0] out_stack_value,
  output logic [7:0] out_status_byte,
  output logic       out_mem_write,
  output logic [7:0] out_mem_data,
  output logic [1:0] out_instr_length,
  output logic [2:0] out_cycle_count,
  output logic       out_unsupported
);
  import cae_pkg::*;

  cae_op_t dec_op;
  cae_op_t q_op;
  logic    q_valid;
  logic    q_ready;

  // decode
  cae_front u_front (
    .in_func         (in_func),
    .in_operand      (in_operand),
    .in_page_crossed (in_page_crossed),
    .op              (dec_op)
  );

  // decoupling queue
  cae_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_op    (dec_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  // execute
  cae_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .op_valid         (q_valid),
    .op_ready         (q_ready),
    .op               (q_op),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_acc_value    (out_acc_value),
    .out_index_value  (out_index_value),
    .out_stack_value  (out_stack_value),
    .out_status_byte  (out_status_byte),
    .out_mem_write    (out_mem_write),
    .out_mem_data     (out_mem_data),
    .out_instr_length (out_instr_length),
    .out_cycle_count  (out_cycle_count),
    .out_unsupported  (out_unsupported)
  );

endmodule
